/* hw/rtl/rlscf_pkg.sv */
package rlscf_pkg;

  localparam int W         = 48;
  localparam int FRAC_BITS = 24;
  localparam int AW        = W + 4;
  localparam int HW        = W / 2;
  localparam int PW        = 2 * W;
  localparam int DW        = W + FRAC_BITS;
  localparam int QVW       = ((PW - FRAC_BITS) > DW ? (PW - FRAC_BITS) : DW) + 1;
  localparam int RV_W      = W - 1;
  localparam int CFG_IDX_W = 3;
  localparam int N         = 4;
  localparam int COV_DEPTH = N * N;

  localparam logic [W-1:0]    Q_ONE         = W'(1) << FRAC_BITS;
  localparam logic [RV_W-1:0] NOISE_VAR_RST = RV_W'(4) << FRAC_BITS;
  localparam logic [RV_W-1:0] INIT_VAR_RST  = RV_W'(10) << FRAC_BITS;
  localparam logic [W-1:0]    COEF_POS_RST  = W'(2) << FRAC_BITS;
  localparam logic [W-1:0]    COEF_NEG_RST  = W'(0) - (W'(2) << FRAC_BITS);

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOISE_VAR = 3'd0,
    CFG_INIT_VAR  = 3'd1,
    CFG_COEF0     = 3'd2,
    CFG_COEF1     = 3'd3,
    CFG_COEF2     = 3'd4,
    CFG_COEF3     = 3'd5
  } cfg_idx_t;

  localparam logic [1:0] ST_UPDATED   = 2'd0;
  localparam logic [1:0] ST_SKIPPED   = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  typedef struct packed {
    logic                cmd;
    logic signed [W-1:0] sample_x;
    logic signed [W-1:0] sample_y;
  } in_item_t;

  typedef struct packed {
    logic signed [W-1:0] coef0;
    logic signed [W-1:0] coef1;
    logic signed [W-1:0] coef2;
    logic signed [W-1:0] coef3;
    logic signed [W-1:0] residual;
    logic [1:0]          status;
  } out_item_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic                start;
    alu_op_t             op;
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                done;
    logic                ovf;
    logic signed [W-1:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic                ovf;
    logic signed [W-1:0] val;
  } sat_t;

  // Clamp a wide exact sum to the 48-bit range and report whether it clipped.
  function automatic sat_t sat_w(input logic signed [AW-1:0] v);
    sat_t r;
    if (v[AW-1:W-1] == '0 || v[AW-1:W-1] == '1) begin
      r.ovf = 1'b0;
      r.val = v[W-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = v[AW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/rlscf_ram.sv */
module rlscf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/rlscf_alu.sv */
module rlscf_alu (
  input  logic                 clk,
  input  logic                 rst,
  input  rlscf_pkg::alu_req_t  req,
  output rlscf_pkg::alu_rsp_t  rsp
);

  localparam int W   = rlscf_pkg::W;
  localparam int HW  = rlscf_pkg::HW;
  localparam int PW  = rlscf_pkg::PW;
  localparam int DW  = rlscf_pkg::DW;
  localparam int QVW = rlscf_pkg::QVW;
  localparam int FB  = rlscf_pkg::FRAC_BITS;
  localparam int CW  = $clog2(DW);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIN  = 4'b1000
  } alu_state_t;

  alu_state_t     state;
  logic [CW-1:0]  cnt;
  logic [W-1:0]   ma;
  logic [W-1:0]   mb;
  logic           neg;
  logic           is_div;
  logic [PW-1:0]  prod;
  logic [W-1:0]   rem;
  logic [DW-1:0]  dvd;
  logic [DW-1:0]  quo;

  logic [HW-1:0]   a_half;
  logic [HW-1:0]   b_half;
  logic [2*HW-1:0] pp;
  logic [1:0]      shift_sel;
  logic [PW-1:0]   pp_sh;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            take;
  logic [QVW-1:0]  qv;
  logic [QVW-1:0]  lim_pos;
  logic [QVW-1:0]  lim_neg;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  // One 24x24 partial product per cycle; the counter bits pick the halves.
  always_comb begin
    a_half    = cnt[0] ? ma[W-1:HW] : ma[HW-1:0];
    b_half    = cnt[1] ? mb[W-1:HW] : mb[HW-1:0];
    pp        = a_half * b_half;
    shift_sel = {1'b0, cnt[0]} + {1'b0, cnt[1]};
    pp_sh     = PW'(pp) << (shift_sel * HW);
    trial     = {rem, dvd[DW-1]};
    take      = trial >= {1'b0, mb};
    diff      = trial - {1'b0, mb};
    if (is_div) begin
      qv = QVW'(quo);
    end else begin
      qv = QVW'(prod[PW-1:FB]) + QVW'(neg && (prod[FB-1:0] != '0));
    end
    lim_pos = QVW'({(W-1){1'b1}});
    lim_neg = QVW'(1) << (W - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == A_FIN);
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            ma     <= mag(req.a);
            mb     <= mag(req.b);
            neg    <= req.a[W-1] ^ req.b[W-1];
            is_div <= (req.op == rlscf_pkg::ALU_DIV);
            cnt    <= '0;
            prod   <= '0;
            rem    <= '0;
            quo    <= '0;
            dvd    <= DW'(mag(req.a)) << FB;
            state  <= (req.op == rlscf_pkg::ALU_DIV) ? A_DIV : A_MUL;
          end
        end
        A_MUL: begin
          prod <= prod + pp_sh;
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(3)) begin
            state <= A_FIN;
          end
        end
        A_DIV: begin
          rem <= take ? diff[W-1:0] : trial[W-1:0];
          quo <= {quo[DW-2:0], take};
          dvd <= dvd << 1;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(DW - 1)) begin
            state <= A_FIN;
          end
        end
        A_FIN: begin
          if (neg) begin
            rsp.ovf <= qv > lim_neg;
            rsp.res <= (qv > lim_neg) ? {1'b1, {(W-1){1'b0}}} : -$signed(qv[W-1:0]);
          end else begin
            rsp.ovf <= qv > lim_pos;
            rsp.res <= (qv > lim_pos) ? {1'b0, {(W-1){1'b1}}} : $signed(qv[W-1:0]);
          end
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/rls_cubic_fit_update_core.sv */
// Recursive least squares fit of a cubic y = a0 + a1 x + a2 x^2 + a3 x^3.
// Input items (in_valid/in_stall) carry cmd, sample_x and sample_y. A restart
// item reloads the coefficients and a diagonal covariance from the config
// registers; a measurement item updates both in gain form. Each input item
// yields exactly one result item (out_valid/out_stall) with the coefficients
// after the step, the prediction residual and a status code.
// The block works on one item at a time. A restart result is loaded once the
// 16-entry covariance memory has been rewritten one entry per cycle. Every
// product and quotient of a measurement goes through one shared unit that
// forms a 48x48 product from four 24x24 partial products and a quotient one
// bit per cycle. The next item can be taken in the cycle after a result is
// loaded.
// The state lives in two synchronous memories; until the first restart they
// read as zero. Reset clears the control state and restores the register
// defaults. When the receiver stalls, the finished result stays in the output
// register and the next result waits until that one is taken.
// Config writes are taken at any time but are meant for idle periods.
module rls_cubic_fit_update_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  rlscf_pkg::in_item_t                     in_item,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output rlscf_pkg::out_item_t                    out_item,
  input  logic                                    cfg_we,
  input  logic [rlscf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rlscf_pkg::W-1:0]                 cfg_data
);

  localparam int W    = rlscf_pkg::W;
  localparam int AW   = rlscf_pkg::AW;
  localparam int RV_W = rlscf_pkg::RV_W;
  localparam int N    = rlscf_pkg::N;
  localparam int NI   = $clog2(N);
  localparam int CD   = rlscf_pkg::COV_DEPTH;

  typedef enum logic [12:0] {
    P_IDLE = 13'b0000000000001,
    P_INIT = 13'b0000000000010,
    P_LDA  = 13'b0000000000100,
    P_X2   = 13'b0000000001000,
    P_X3   = 13'b0000000010000,
    P_HA   = 13'b0000000100000,
    P_PH   = 13'b0000001000000,
    P_HP   = 13'b0000010000000,
    P_S    = 13'b0000100000000,
    P_K    = 13'b0001000000000,
    P_A    = 13'b0010000000000,
    P_PU   = 13'b0100000000000,
    P_OUT  = 13'b1000000000000
  } phase_t;

  typedef enum logic [2:0] {
    S_RD = 3'b001,
    S_GO = 3'b010,
    S_WT = 3'b100
  } sub_t;

  // Configuration registers.
  logic [RV_W-1:0]     noise_var;
  logic [RV_W-1:0]     init_var;
  logic signed [W-1:0] init_coef [N];

  // Sequencer and working registers.
  phase_t              phase;
  sub_t                sub;
  logic [NI-1:0]       i;
  logic [NI-1:0]       j;
  logic                started;
  logic                flag;
  logic [1:0]          st;
  logic signed [W-1:0] x;
  logic signed [W-1:0] y;
  logic signed [W-1:0] h     [N];
  logic signed [W-1:0] ph_v  [N];
  logic signed [W-1:0] hp_v  [N];
  logic signed [W-1:0] k_v   [N];
  logic signed [W-1:0] a_v   [N];
  logic signed [AW-1:0] acc;
  logic signed [W-1:0] s_v;
  logic signed [W-1:0] resid;
  logic signed [W-1:0] p_hold;

  // Memory ports.
  logic                cov_we;
  logic [2*NI-1:0]     cov_waddr;
  logic [W-1:0]        cov_wdata;
  logic [2*NI-1:0]     cov_raddr;
  logic [W-1:0]        cov_rdata;
  logic                coef_we;
  logic [NI-1:0]       coef_waddr;
  logic [W-1:0]        coef_wdata;
  logic [W-1:0]        coef_rdata;
  logic signed [W-1:0] cov_q;
  logic signed [W-1:0] coef_q;

  rlscf_pkg::alu_req_t alu_req;
  rlscf_pkg::alu_rsp_t alu_rsp;

  logic                wt_done;
  logic signed [AW-1:0] acc_sum;
  rlscf_pkg::sat_t     acc_sat;
  rlscf_pkg::sat_t     resid_sat;
  rlscf_pkg::sat_t     a_sat;
  rlscf_pkg::sat_t     p_sat;
  logic                flag_next;

  rlscf_ram #(.WIDTH(W), .DEPTH(CD)) u_cov_ram (
    .clk   (clk),
    .we    (cov_we),
    .waddr (cov_waddr),
    .wdata (cov_wdata),
    .raddr (cov_raddr),
    .rdata (cov_rdata)
  );

  rlscf_ram #(.WIDTH(W), .DEPTH(N)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (j),
    .rdata (coef_rdata)
  );

  rlscf_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_var    <= rlscf_pkg::NOISE_VAR_RST;
      init_var     <= rlscf_pkg::INIT_VAR_RST;
      init_coef[0] <= rlscf_pkg::COEF_NEG_RST;
      init_coef[1] <= rlscf_pkg::COEF_POS_RST;
      init_coef[2] <= rlscf_pkg::COEF_NEG_RST;
      init_coef[3] <= rlscf_pkg::COEF_POS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlscf_pkg::CFG_NOISE_VAR: noise_var    <= cfg_data[RV_W-1:0];
        rlscf_pkg::CFG_INIT_VAR:  init_var     <= cfg_data[RV_W-1:0];
        rlscf_pkg::CFG_COEF0:     init_coef[0] <= cfg_data;
        rlscf_pkg::CFG_COEF1:     init_coef[1] <= cfg_data;
        rlscf_pkg::CFG_COEF2:     init_coef[2] <= cfg_data;
        rlscf_pkg::CFG_COEF3:     init_coef[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Until the first restart the memories hold nothing valid and read as zero.
  assign cov_q    = started ? cov_rdata : '0;
  assign coef_q   = started ? coef_rdata : '0;
  assign in_stall = rst || (phase != P_IDLE);
  assign wt_done  = (sub == S_WT) && alu_rsp.done;

  // The column pass of h'P walks the covariance transposed.
  assign cov_raddr = (phase == P_HP) ? {j, i} : {i, j};

  always_comb begin
    acc_sum   = acc + AW'(alu_rsp.res);
    acc_sat   = rlscf_pkg::sat_w(acc_sum);
    resid_sat = rlscf_pkg::sat_w(AW'(y) - AW'(acc_sat.val));
    a_sat     = rlscf_pkg::sat_w(AW'(a_v[j]) + AW'(alu_rsp.res));
    p_sat     = rlscf_pkg::sat_w(AW'(p_hold) - AW'(alu_rsp.res));

    flag_next = flag | alu_rsp.ovf;
    unique case (phase)
      P_HA:             flag_next = flag_next | ((j == NI'(N - 1)) &&
                                                 (acc_sat.ovf || resid_sat.ovf));
      P_PH, P_HP, P_S:  flag_next = flag_next | ((j == NI'(N - 1)) && acc_sat.ovf);
      P_A:              flag_next = flag_next | a_sat.ovf;
      P_PU:             flag_next = flag_next | p_sat.ovf;
      default: ;
    endcase
  end

  always_comb begin
    cov_we     = 1'b0;
    cov_waddr  = {i, j};
    cov_wdata  = p_sat.val;
    coef_we    = 1'b0;
    coef_waddr = j;
    coef_wdata = a_sat.val;
    unique case (phase)
      P_INIT: begin
        cov_we     = 1'b1;
        cov_wdata  = (i == j) ? W'(init_var) : '0;
        coef_we    = (i == '0);
        coef_wdata = init_coef[j];
      end
      P_A:  coef_we = wt_done;
      P_PU: cov_we  = wt_done;
      default: ;
    endcase
  end

  always_comb begin
    alu_req.start = (sub == S_GO) && (phase != P_LDA) && (phase != P_IDLE) &&
                    (phase != P_INIT) && (phase != P_OUT);
    alu_req.op    = (phase == P_K) ? rlscf_pkg::ALU_DIV : rlscf_pkg::ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    unique case (phase)
      P_X2: begin alu_req.a = x;       alu_req.b = x;      end
      P_X3: begin alu_req.a = h[2];    alu_req.b = x;      end
      P_HA: begin alu_req.a = h[j];    alu_req.b = a_v[j]; end
      P_PH: begin alu_req.a = cov_q;   alu_req.b = h[j];   end
      P_HP: begin alu_req.a = h[j];    alu_req.b = cov_q;  end
      P_S:  begin alu_req.a = h[j];    alu_req.b = ph_v[j]; end
      P_K:  begin alu_req.a = ph_v[j]; alu_req.b = s_v;    end
      P_A:  begin alu_req.a = k_v[j];  alu_req.b = resid;  end
      P_PU: begin alu_req.a = k_v[i];  alu_req.b = hp_v[j]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= P_IDLE;
      sub       <= S_RD;
      i         <= '0;
      j         <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (phase != P_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (phase)
        P_IDLE: begin
          if (in_valid) begin
            x     <= in_item.sample_x;
            y     <= in_item.sample_y;
            h[0]  <= rlscf_pkg::Q_ONE;
            h[1]  <= in_item.sample_x;
            i     <= '0;
            j     <= '0;
            sub   <= S_RD;
            flag  <= 1'b0;
            phase <= (in_item.cmd == rlscf_pkg::CMD_RESTART) ? P_INIT : P_LDA;
          end
        end
        P_INIT: begin
          {i, j} <= {i, j} + (2*NI)'(1);
          if (i == NI'(N - 1) && j == NI'(N - 1)) begin
            started <= 1'b1;
            for (int n = 0; n < N; n++) begin
              a_v[n] <= init_coef[n];
            end
            resid <= '0;
            st    <= rlscf_pkg::ST_UPDATED;
            phase <= P_OUT;
          end
        end
        P_LDA: begin
          if (sub == S_RD) begin
            sub <= S_GO;
          end else begin
            a_v[j] <= coef_q;
            sub    <= S_RD;
            j      <= j + NI'(1);
            if (j == NI'(N - 1)) begin
              phase <= P_X2;
            end
          end
        end
        P_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            out_item.coef0    <= a_v[0];
            out_item.coef1    <= a_v[1];
            out_item.coef2    <= a_v[2];
            out_item.coef3    <= a_v[3];
            out_item.residual <= resid;
            out_item.status   <= st;
            phase             <= P_IDLE;
          end
        end
        default: begin
          unique case (sub)
            S_RD: sub <= S_GO;
            S_GO: begin
              sub    <= S_WT;
              p_hold <= cov_q;
            end
            S_WT: begin
              if (alu_rsp.done) begin
                sub <= S_RD;
              end
            end
            default: sub <= S_RD;
          endcase
        end
      endcase

      if (wt_done) begin
        flag <= flag_next;
        unique case (phase)
          P_X2: begin
            h[2]  <= alu_rsp.res;
            phase <= P_X3;
          end
          P_X3: begin
            h[3]  <= alu_rsp.res;
            acc   <= '0;
            phase <= P_HA;
          end
          P_HA: begin
            j <= j + NI'(1);
            if (j == NI'(N - 1)) begin
              resid <= resid_sat.val;
              acc   <= '0;
              phase <= P_PH;
            end else begin
              acc <= acc_sum;
            end
          end
          P_PH: begin
            {i, j} <= {i, j} + (2*NI)'(1);
            if (j == NI'(N - 1)) begin
              ph_v[i] <= acc_sat.val;
              acc     <= '0;
              if (i == NI'(N - 1)) begin
                phase <= P_HP;
              end
            end else begin
              acc <= acc_sum;
            end
          end
          P_HP: begin
            {i, j} <= {i, j} + (2*NI)'(1);
            if (j == NI'(N - 1)) begin
              hp_v[i] <= acc_sat.val;
              if (i == NI'(N - 1)) begin
                acc   <= AW'({1'b0, noise_var});
                phase <= P_S;
              end else begin
                acc <= '0;
              end
            end else begin
              acc <= acc_sum;
            end
          end
          P_S: begin
            acc <= acc_sum;
            j   <= j + NI'(1);
            if (j == NI'(N - 1)) begin
              s_v <= acc_sat.val;
              if (acc_sat.val[W-1] || acc_sat.val == '0) begin
                st    <= rlscf_pkg::ST_SKIPPED;
                phase <= P_OUT;
              end else begin
                phase <= P_K;
              end
            end
          end
          P_K: begin
            k_v[j] <= alu_rsp.res;
            j      <= j + NI'(1);
            if (j == NI'(N - 1)) begin
              phase <= P_A;
            end
          end
          P_A: begin
            a_v[j] <= a_sat.val;
            j      <= j + NI'(1);
            if (j == NI'(N - 1)) begin
              phase <= P_PU;
            end
          end
          P_PU: begin
            {i, j} <= {i, j} + (2*NI)'(1);
            if (i == NI'(N - 1) && j == NI'(N - 1)) begin
              st    <= flag_next ? rlscf_pkg::ST_SATURATED : rlscf_pkg::ST_UPDATED;
              phase <= P_OUT;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // An accepted item always starts a sequence.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (phase != P_IDLE))
    else $error("accepted item did not leave idle");

  // Results from the shared unit arrive only while the sequencer waits for one.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (sub == S_WT))
    else $error("arithmetic result arrived outside a wait step");

  // The coefficient memory changes only on restart or on the coefficient update.
  a_coef_write_phase: assert property (@(posedge clk) disable iff (rst)
    coef_we |-> (phase == P_INIT || phase == P_A))
    else $error("coefficient memory written in a wrong phase");

  // A new result is never loaded over one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("pending result was dropped");

endmodule

/* dv/rls_cubic_fit_update_checker.sv */
module rls_cubic_fit_update_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  rlscf_pkg::in_item_t             in_item,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  rlscf_pkg::out_item_t            out_item,
  input  logic                            cfg_we,
  input  logic [rlscf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlscf_pkg::W-1:0]         cfg_data,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W         = rlscf_pkg::W;
  localparam int N         = rlscf_pkg::N;
  localparam int RV_W      = rlscf_pkg::RV_W;
  localparam int COV_DEPTH = rlscf_pkg::COV_DEPTH;
  localparam int FRAC_BITS = rlscf_pkg::FRAC_BITS;

  typedef logic signed [127:0] wide_t;
  localparam wide_t MAX_V = wide_t'(48'sh7FFF_FFFF_FFFF);
  localparam wide_t MIN_V = -wide_t'(48'sh7FFF_FFFF_FFFF) - 1;

  logic [RV_W-1:0]      noise_var, init_var;
  logic signed [W-1:0]  init_coef [N];
  logic signed [W-1:0]  coef [N];
  logic signed [W-1:0]  cov [COV_DEPTH];
  bit                   clipped;
  rlscf_pkg::out_item_t fit_results [$];

  // Clamp an exact value to 48 bits and remember that it clipped.
  function automatic logic signed [W-1:0] clamp48(wide_t v);
    if (v > MAX_V) begin
      clipped = 1'b1;
      return MAX_V[W-1:0];
    end
    if (v < MIN_V) begin
      clipped = 1'b1;
      return MIN_V[W-1:0];
    end
    return v[W-1:0];
  endfunction

  // Product rounded toward minus infinity by the arithmetic shift.
  function automatic logic signed [W-1:0] fx_mul(logic signed [W-1:0] a,
                                                 logic signed [W-1:0] b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return clamp48(p >>> FRAC_BITS);
  endfunction

  // Signed division truncates toward zero, as the gain requires.
  function automatic logic signed [W-1:0] fx_div(logic signed [W-1:0] num,
                                                 logic signed [W-1:0] den);
    wide_t n;
    n = wide_t'(num) <<< FRAC_BITS;
    return clamp48(n / wide_t'(den));
  endfunction

  function automatic rlscf_pkg::out_item_t fit_step(rlscf_pkg::in_item_t it);
    rlscf_pkg::out_item_t r;
    logic signed [W-1:0] h [N];
    logic signed [W-1:0] ph [N];
    logic signed [W-1:0] hp [N];
    logic signed [W-1:0] k [N];
    logic signed [W-1:0] res, s;
    wide_t acc, sr, sc;
    res = '0;
    r.status = rlscf_pkg::ST_UPDATED;
    if (it.cmd == rlscf_pkg::CMD_RESTART) begin
      for (int i = 0; i < N; i++) coef[i] = init_coef[i];
      for (int i = 0; i < COV_DEPTH; i++) cov[i] = '0;
      for (int i = 0; i < N; i++) cov[i*5] = {1'b0, init_var};
    end else begin
      clipped = 1'b0;
      h[0] = rlscf_pkg::Q_ONE;
      h[1] = it.sample_x;
      h[2] = fx_mul(it.sample_x, it.sample_x);
      h[3] = fx_mul(h[2], it.sample_x);
      acc = '0;
      for (int i = 0; i < N; i++) acc += wide_t'(fx_mul(h[i], coef[i]));
      acc = wide_t'(clamp48(acc));
      res = clamp48(wide_t'(it.sample_y) - acc);
      for (int i = 0; i < N; i++) begin
        sr = '0;
        sc = '0;
        for (int j = 0; j < N; j++) begin
          sr += wide_t'(fx_mul(cov[i*4+j], h[j]));
          sc += wide_t'(fx_mul(h[j], cov[j*4+i]));
        end
        ph[i] = clamp48(sr);
        hp[i] = clamp48(sc);
      end
      acc = wide_t'({1'b0, noise_var});
      for (int i = 0; i < N; i++) acc += wide_t'(fx_mul(h[i], ph[i]));
      s = clamp48(acc);
      if (s <= 0) begin
        r.status = rlscf_pkg::ST_SKIPPED;
      end else begin
        for (int i = 0; i < N; i++) k[i] = fx_div(ph[i], s);
        for (int i = 0; i < N; i++)
          coef[i] = clamp48(wide_t'(coef[i]) + wide_t'(fx_mul(k[i], res)));
        for (int i = 0; i < N; i++)
          for (int j = 0; j < N; j++)
            cov[i*4+j] = clamp48(wide_t'(cov[i*4+j]) - wide_t'(fx_mul(k[i], hp[j])));
        r.status = clipped ? rlscf_pkg::ST_SATURATED : rlscf_pkg::ST_UPDATED;
      end
    end
    r.coef0 = coef[0];
    r.coef1 = coef[1];
    r.coef2 = coef[2];
    r.coef3 = coef[3];
    r.residual = res;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  assign pending = fit_results.size();

  always @(posedge clk) begin
    rlscf_pkg::out_item_t want;
    if (rst) begin
      errors = 0;
      noise_var <= rlscf_pkg::NOISE_VAR_RST;
      init_var  <= rlscf_pkg::INIT_VAR_RST;
      init_coef[0] = rlscf_pkg::COEF_NEG_RST;
      init_coef[1] = rlscf_pkg::COEF_POS_RST;
      init_coef[2] = rlscf_pkg::COEF_NEG_RST;
      init_coef[3] = rlscf_pkg::COEF_POS_RST;
      for (int i = 0; i < N; i++) coef[i] = '0;
      for (int i = 0; i < COV_DEPTH; i++) cov[i] = '0;
      fit_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rlscf_pkg::CFG_NOISE_VAR: noise_var <= cfg_data[RV_W-1:0];
          rlscf_pkg::CFG_INIT_VAR:  init_var  <= cfg_data[RV_W-1:0];
          rlscf_pkg::CFG_COEF0:     init_coef[0] = cfg_data;
          rlscf_pkg::CFG_COEF1:     init_coef[1] = cfg_data;
          rlscf_pkg::CFG_COEF2:     init_coef[2] = cfg_data;
          rlscf_pkg::CFG_COEF3:     init_coef[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) fit_results = {fit_results, fit_step(in_item)};
      if (out_valid && !out_stall) begin
        if (fit_results.size() == 0) begin
          report_mismatch("unexpected result item", '0, '0);
        end else begin
          want = fit_results.pop_front();
          if (out_item.coef0 !== want.coef0) report_mismatch("coef0", out_item.coef0, want.coef0);
          if (out_item.coef1 !== want.coef1) report_mismatch("coef1", out_item.coef1, want.coef1);
          if (out_item.coef2 !== want.coef2) report_mismatch("coef2", out_item.coef2, want.coef2);
          if (out_item.coef3 !== want.coef3) report_mismatch("coef3", out_item.coef3, want.coef3);
          if (out_item.residual !== want.residual)
            report_mismatch("residual", out_item.residual, want.residual);
          if (out_item.status !== want.status)
            report_mismatch("status", W'(out_item.status), W'(want.status));
        end
      end
    end
  end

endmodule

/* dv/tb_rls_cubic_fit_update_core.sv */
module tb_rls_cubic_fit_update_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W           = rlscf_pkg::W;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 365;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  rlscf_pkg::in_item_t             in_item;
  logic                            out_valid;
  logic                            out_stall;
  rlscf_pkg::out_item_t            out_item;
  logic                            cfg_we;
  logic [rlscf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [W-1:0]                    cfg_data;
  int                              errors;
  int                              pending;
  bit                              steady;
  int                              quiet_cycles;

  localparam logic signed [W-1:0] MAX_Q = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_Q = {1'b1, {(W-1){1'b0}}};

  rls_cubic_fit_update_core DUT (.*);

  rls_cubic_fit_update_checker fit_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [W-1:0] any_q();
    return W'({$urandom, $urandom});
  endfunction

  // Values within about +-4.0 keep the fit well conditioned.
  function automatic logic signed [W-1:0] modest_q();
    return W'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
  endfunction

  task automatic send(logic cmd, logic signed [W-1:0] x, logic signed [W-1:0] y);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item.cmd = cmd;
    in_item.sample_x = x;
    in_item.sample_y = y;
    in_valid = 1'b1;
    while (in_stall) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(rlscf_pkg::cfg_idx_t idx, logic [W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic load_setup(logic [W-1:0] r, logic [W-1:0] p0, logic [W-1:0] c0,
                            logic [W-1:0] c1, logic [W-1:0] c2, logic [W-1:0] c3);
    write_reg(rlscf_pkg::CFG_NOISE_VAR, r);
    write_reg(rlscf_pkg::CFG_INIT_VAR, p0);
    write_reg(rlscf_pkg::CFG_COEF0, c0);
    write_reg(rlscf_pkg::CFG_COEF1, c1);
    write_reg(rlscf_pkg::CFG_COEF2, c2);
    write_reg(rlscf_pkg::CFG_COEF3, c3);
  endtask

  // Receiver side: a random stall before each result item, none in steady stretches.
  initial begin
    int hold;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 4);
      out_stall = 1'b1;
      repeat (hold) @(negedge clk);
      out_stall = 1'b0;
      while (!out_valid) @(negedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // A measurement on the zero state, then one with zero noise so the
    // denominator vanishes and the update is skipped.
    send(rlscf_pkg::CMD_MEASURE, 48'sh100_0000, 48'sh300_0000);
    drain();
    write_reg(rlscf_pkg::CFG_NOISE_VAR, '0);
    send(rlscf_pkg::CMD_MEASURE, 48'sh200_0000, -48'sh100_0000);
    drain();
    write_reg(rlscf_pkg::CFG_NOISE_VAR, W'(rlscf_pkg::NOISE_VAR_RST));

    send(rlscf_pkg::CMD_RESTART, '0, '0);
    send(rlscf_pkg::CMD_MEASURE, '0, 48'sh100_0000);
    send(rlscf_pkg::CMD_MEASURE, 48'sh100_0000, 48'sh200_0000);
    send(rlscf_pkg::CMD_MEASURE, -48'sh100_0000, -48'sh400_0000);
    send(rlscf_pkg::CMD_MEASURE, 48'sh20_0000, 48'sh80_0000);
    send(rlscf_pkg::CMD_MEASURE, MAX_Q, '0);
    send(rlscf_pkg::CMD_MEASURE, MIN_Q, MAX_Q);
    send(rlscf_pkg::CMD_RESTART, MAX_Q, MIN_Q);
    send(rlscf_pkg::CMD_MEASURE, '0, MIN_Q);
    send(rlscf_pkg::CMD_MEASURE, '0, MAX_Q);
    send(rlscf_pkg::CMD_MEASURE, 48'sh1, -48'sh1);
    send(rlscf_pkg::CMD_MEASURE, -48'sh1, 48'sh1);
    send(rlscf_pkg::CMD_RESTART, '0, '0);
    send(rlscf_pkg::CMD_MEASURE, 48'sh300_0000, 48'sh1B00_0000);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_setup(W'(rlscf_pkg::NOISE_VAR_RST), W'(rlscf_pkg::INIT_VAR_RST),
                      rlscf_pkg::COEF_NEG_RST, rlscf_pkg::COEF_POS_RST,
                      rlscf_pkg::COEF_NEG_RST, rlscf_pkg::COEF_POS_RST);
        1: load_setup(48'h1, {1'b0, {(W-1){1'b1}}}, MIN_Q, MAX_Q, MIN_Q, MAX_Q);
        2: load_setup({1'b0, {(W-1){1'b1}}}, 48'h1, MAX_Q, MIN_Q, MAX_Q, MIN_Q);
        default: load_setup(W'($urandom_range(1, 32'h4000_0000)),
                            W'($urandom_range(1, 32'h4000_0000)),
                            modest_q(), modest_q(), modest_q(), modest_q());
      endcase
      send(rlscf_pkg::CMD_RESTART, any_q(), any_q());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 90 == 0) steady = ($urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 3)
          send(rlscf_pkg::CMD_RESTART, any_q(), any_q());
        else if (pick < 11)
          send(rlscf_pkg::CMD_MEASURE, any_q(), any_q());
        else
          send(rlscf_pkg::CMD_MEASURE, modest_q(), modest_q());
      end
      steady = 1'b0;
      drain();
    end

    repeat (50) @(negedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rlscf_pkg.sv
hw/rtl/rlscf_ram.sv
hw/rtl/rlscf_alu.sv
hw/rtl/rls_cubic_fit_update_core.sv
dv/rls_cubic_fit_update_checker.sv
dv/tb_rls_cubic_fit_update_core.sv
